// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, codes and sizes of the sorted key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int INDEX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic          load;        // capture the input beat
    logic          do_insert;   // shift up and place new entry
    logic          do_delete;   // shift down over the hit entry
    logic          res_load;    // write the result register
    logic          show_pay;    // result carries the found payload
    status_t       res_status;
  } skt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            full;
    logic            empty;
  } skt_stat_t;

endpackage

`default_nettype wire

// ----- hdl/skt_in_if.sv -----
// ----------------------------------------------------------------------------
// skt_in_if
// request channel: operation, key and payload with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skt_in_if;
  logic                              valid;
  logic                              ready;
  logic [skt_pkg::OP_W-1:0]          operation;
  logic signed [skt_pkg::KEY_W-1:0]  key;
  logic [skt_pkg::PAY_W-1:0]         payload_in;

  modport source (output valid, operation, key, payload_in, input ready);
  modport sink   (input valid, operation, key, payload_in, output ready);
endinterface

`default_nettype wire

// ----- hdl/skt_out_if.sv -----
// ----------------------------------------------------------------------------
// skt_out_if
// result channel: status, payload and entry count with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skt_out_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::STATUS_W-1:0]  status;
  logic [skt_pkg::PAY_W-1:0]     payload_out;
  logic [skt_pkg::ENTRY_W-1:0]   entry_count;

  modport source (output valid, status, payload_out, entry_count, input ready);
  modport sink   (input valid, status, payload_out, entry_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/sorted_key_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_core
// ordered dictionary of signed keys with 64-bit payloads, insert/delete/lookup
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY (16) entries in cells kept in ascending
// signed key order. Each request beat gives exactly one result beat with a
// status (ok, full, duplicate, empty, not found), the payload found by a
// lookup (zero otherwise) and the entry count after the operation. A request
// passes two steps: capture of the beat, then execute, in which every cell
// compares its key against the request key in parallel and the row shifts up
// or down in place. The result sits in an output register, so the next
// request is taken while a result still waits; a stalled result holds the
// execute step, and with it the next request. A new request is taken only
// once the last one has left the execute step. Cell contents above the entry
// count are never read, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_core (
  input  wire       clk,
  input  wire       rst,
  skt_in_if.sink    req,
  skt_out_if.source rsp
);

  // command and status between sequencer and cell row
  skt_pkg::skt_cmd_t  cmd;
  skt_pkg::skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // cells, compare network and the result register
  skt_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (req.operation),
    .in_key     (req.key),
    .in_pay     (req.payload_in),
    .res_status (rsp.status),
    .res_pay    (rsp.payload_out),
    .res_count  (rsp.entry_count)
  );

endmodule

`default_nettype wire

// ----- hdl/skt_datapath.sv -----
// ----------------------------------------------------------------------------
// skt_datapath
// row of key/payload cells with parallel compare, shift and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_datapath (
  input  wire                             clk,
  input  wire                             rst,
  input  skt_pkg::skt_cmd_t               cmd,
  output skt_pkg::skt_stat_t              stat,
  input  wire [skt_pkg::OP_W-1:0]         in_op,
  input  wire signed [skt_pkg::KEY_W-1:0] in_key,
  input  wire [skt_pkg::PAY_W-1:0]        in_pay,
  output logic [skt_pkg::STATUS_W-1:0]    res_status,
  output logic [skt_pkg::PAY_W-1:0]       res_pay,
  output logic [skt_pkg::ENTRY_W-1:0]     res_count
);

  localparam int N = skt_pkg::CAPACITY;

  // captured beat
  logic [skt_pkg::OP_W-1:0]         op;
  logic signed [skt_pkg::KEY_W-1:0] key;
  logic [skt_pkg::PAY_W-1:0]        pay;

  // cells
  logic signed [skt_pkg::KEY_W-1:0] keys [N];
  logic [skt_pkg::PAY_W-1:0]        pays [N];
  logic [skt_pkg::COUNT_W-1:0]      count;
  logic [skt_pkg::COUNT_W-1:0]      count_next;

  logic [N-1:0]              lt;
  logic [N-1:0]              eq;
  logic [skt_pkg::PAY_W-1:0] hit_pay;

  always_comb begin
    hit_pay = '0;
    for (int i = 0; i < N; i++) begin
      lt[i] = (skt_pkg::COUNT_W'(i) < count) && (keys[i] < key);
      eq[i] = (skt_pkg::COUNT_W'(i) < count) && (keys[i] == key);
      if (eq[i]) begin
        hit_pay = hit_pay | pays[i];
      end
    end
  end

  always_comb begin
    stat       = '0;
    stat.op    = op;
    stat.hit   = |eq;
    stat.full  = (count == skt_pkg::COUNT_W'(N));
    stat.empty = (count == '0);
  end

  always_comb begin
    count_next = count;
    if (cmd.do_insert) begin
      count_next = count + 1'b1;
    end else if (cmd.do_delete) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_op;
      key <= in_key;
      pay <= in_pay;
    end
  end

  // each cell keeps, takes the new entry, or takes a neighbor
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (cmd.do_insert && !lt[i]) begin
        if (i == 0 || lt[(i == 0) ? 0 : i - 1]) begin
          keys[i] <= key;
          pays[i] <= pay;
        end else begin
          keys[i] <= keys[(i == 0) ? 0 : i - 1];
          pays[i] <= pays[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd.do_delete && !lt[i] && i < N - 1) begin
        keys[i] <= keys[(i < N - 1) ? i + 1 : i];
        pays[i] <= pays[(i < N - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_pay    <= cmd.show_pay ? hit_pay : '0;
      res_count  <= skt_pkg::ENTRY_W'(count_next);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// sequencer: accepts a beat, decides the outcome, drives the result handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  input  skt_pkg::skt_stat_t       stat,
  output skt_pkg::skt_cmd_t        cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   can_write;

  assign in_ready  = (state == IDLE);
  assign can_write = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.res_status = skt_pkg::ST_OK;
    cmd.load       = in_valid && in_ready;
    if (state == EXEC && can_write) begin
      cmd.res_load = 1'b1;
      case (stat.op)
        skt_pkg::OP_INSERT: begin
          if (stat.full) begin
            cmd.res_status = skt_pkg::ST_FULL;
          end else if (stat.hit) begin
            cmd.res_status = skt_pkg::ST_DUP;
          end else begin
            cmd.do_insert = 1'b1;
          end
        end
        skt_pkg::OP_DELETE: begin
          if (stat.empty) begin
            cmd.res_status = skt_pkg::ST_EMPTY;
          end else if (!stat.hit) begin
            cmd.res_status = skt_pkg::ST_MISSING;
          end else begin
            cmd.do_delete = 1'b1;
          end
        end
        skt_pkg::OP_LOOKUP: begin
          if (stat.empty) begin
            cmd.res_status = skt_pkg::ST_EMPTY;
          end else if (!stat.hit) begin
            cmd.res_status = skt_pkg::ST_MISSING;
          end else begin
            cmd.show_pay = 1'b1;
          end
        end
        default: begin
          cmd.res_status = skt_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (can_write) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks sorted_key_table_core: request beats go in through a bursty driver,
// result beats come out under a stalling sink and are compared field by field
// against an in-bench ordered-table predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import skt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct {
    op_t                      op;
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         pay;
  } table_req_t;

  typedef struct {
    status_t                  status;
    logic [PAY_W-1:0]         payload;
    logic [ENTRY_W-1:0]       count;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst;

  skt_in_if  req_if ();
  skt_out_if rsp_if ();

  sorted_key_table_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // request beats waiting to be driven, and results owed by the block
  table_req_t request_q[$];
  table_rsp_t owed_rsp_q[$];
  int         total_reqs;
  int         accepted_reqs = 0;
  int         error_count = 0;

  // shadow of the table contents, kept in ascending signed key order
  logic signed [KEY_W-1:0] shadow_keys[CAPACITY];
  logic [PAY_W-1:0]        shadow_pays[CAPACITY];
  int                      shadow_fill = 0;

  // apply one request to the shadow table and return the result it owes
  function automatic table_rsp_t apply_to_shadow(table_req_t r);
    table_rsp_t res;
    int         pos;
    logic       hit;
    res = '{ST_OK, '0, '0};
    pos = 0;
    while (pos < shadow_fill && shadow_keys[pos] < r.key) pos++;
    hit = (pos < shadow_fill) && (shadow_keys[pos] == r.key);
    case (r.op)
      OP_INSERT: begin
        // fullness wins over the duplicate test
        if (shadow_fill >= CAPACITY) res.status = ST_FULL;
        else if (hit) res.status = ST_DUP;
        else begin
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[pos] = r.key;
          shadow_pays[pos] = r.pay;
          shadow_fill++;
        end
      end
      OP_DELETE: begin
        if (shadow_fill == 0) res.status = ST_EMPTY;
        else if (!hit) res.status = ST_MISSING;
        else begin
          for (int i = pos; i + 1 < shadow_fill; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
          end
          shadow_fill--;
        end
      end
      OP_LOOKUP: begin
        if (shadow_fill == 0) res.status = ST_EMPTY;
        else if (!hit) res.status = ST_MISSING;
        else res.payload = shadow_pays[pos];
      end
      default: ;  // spare op code: nothing changes, status ok
    endcase
    res.count = shadow_fill[ENTRY_W-1:0];
    return res;
  endfunction

  task automatic queue_request(op_t op, logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    request_q.push_back('{op, k, p});
  endtask

  // --------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int         burst_left = 0;
  int         gap_left = 0;
  table_req_t drive_req;
  table_req_t taken_req;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      // a beat taken on this edge is predicted in acceptance order
      if (req_if.valid && req_if.ready) begin
        taken_req = '{op_t'(req_if.operation), req_if.key, req_if.payload_in};
        owed_rsp_q.push_back(apply_to_shadow(taken_req));
        accepted_reqs++;
      end
      // the slot is free when nothing is offered or the offer was just taken
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          drive_req = request_q.pop_front();
          req_if.operation  <= drive_req.op;
          req_if.key        <= drive_req.key;
          req_if.payload_in <= drive_req.pay;
          req_if.valid      <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // about one burst in four runs straight into the next
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result sink: an 8-bit phase cycles through always-ready, random and long stalls
  // --------------------------------------------------------------------------
  logic [7:0] sink_phase;
  int         stall_left;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      sink_phase   <= '0;
      stall_left   <= 0;
    end else begin
      sink_phase <= sink_phase + 8'd1;
      case (sink_phase[7:6])
        2'd0: rsp_if.ready <= 1'b1;
        2'd1: rsp_if.ready <= ($urandom_range(3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
          end else if ($urandom_range(7) == 0) begin
            stall_left   <= $urandom_range(1, 12);
            rsp_if.ready <= 1'b0;
          end else begin
            rsp_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: each beat against the oldest owed result
  // --------------------------------------------------------------------------
  table_rsp_t want_rsp;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (owed_rsp_q.size() == 0) begin
        $error("result beat with none owed: status %0d payload %h count %0d",
               rsp_if.status, rsp_if.payload_out, rsp_if.entry_count);
        error_count++;
      end else begin
        want_rsp = owed_rsp_q.pop_front();
        if (rsp_if.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.payload_out !== want_rsp.payload) begin
          $error("payload_out: expected %h, got %h", want_rsp.payload, rsp_if.payload_out);
          error_count++;
        end
        if (rsp_if.entry_count !== want_rsp.count) begin
          $error("entry_count: expected %0d, got %0d", want_rsp.count, rsp_if.entry_count);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no beat on either side ends the run
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic signed [KEY_W-1:0] key_pool[24];
    logic signed [KEY_W-1:0] pick_key;
    int                      insert_pct;
    int                      roll;
    op_t                     pick_op;

    rst = 1'b1;
    req_if.valid      = 1'b0;
    req_if.operation  = '0;
    req_if.key        = '0;
    req_if.payload_in = '0;
    rsp_if.ready      = 1'b0;

    // directed: empty table, key extremes, every op, miss and duplicate
    queue_request(OP_LOOKUP, 32'sd0, 64'h0);
    queue_request(OP_DELETE, -32'sd1, 64'h0);
    queue_request(OP_INSERT, KEY_MIN, 64'hffff_ffff_ffff_ffff);
    queue_request(OP_INSERT, KEY_MAX, 64'h0);
    queue_request(OP_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef);
    queue_request(OP_INSERT, KEY_MIN, 64'h5555_5555_5555_5555);
    queue_request(OP_LOOKUP, KEY_MIN, 64'h0);
    queue_request(OP_LOOKUP, KEY_MAX, 64'hffff_ffff_ffff_ffff);
    queue_request(OP_LOOKUP, 32'sd5, 64'h0);
    queue_request(OP_DELETE, 32'sd5, 64'h0);
    queue_request(OP_NOP, KEY_MAX, 64'hffff_ffff_ffff_ffff);
    queue_request(OP_DELETE, 32'sd0, 64'h0);
    // fill up to capacity, then insert into the full table (new and duplicate)
    for (int i = 0; i < CAPACITY - 2; i++)
      queue_request(OP_INSERT, (i - 7) * 1000, {$urandom, $urandom});
    queue_request(OP_INSERT, 32'sd12345, 64'h1);
    queue_request(OP_INSERT, KEY_MIN, 64'h2);

    // random: stretches biased toward filling, churning and draining,
    // keys mostly from a small per-stretch pool so hits are common
    for (int chunk = 0; chunk < 17; chunk++) begin
      insert_pct = (chunk % 3 == 0) ? 80 : (chunk % 3 == 1) ? 45 : 15;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < 24; i++) key_pool[i] = $urandom;
      key_pool[5] = key_pool[4] + 1;  // neighbors exercise the ordering
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(99);
        if (roll < 2) pick_op = OP_NOP;
        else if (roll < insert_pct) pick_op = OP_INSERT;
        else if ($urandom_range(1) == 0) pick_op = OP_DELETE;
        else pick_op = OP_LOOKUP;
        pick_key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(23)];
        queue_request(pick_op, pick_key, {$urandom, $urandom});
      end
    end
    total_reqs = request_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (accepted_reqs != total_reqs) @(negedge clk);
    while (owed_rsp_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sorted_key_table_core.f -----
hdl/skt_pkg.sv
hdl/skt_in_if.sv
hdl/skt_out_if.sv
hdl/skt_datapath.sv
hdl/skt_ctrl.sv
hdl/sorted_key_table_core.sv
bench/tb_top.sv
